FILE: design/assert_macros.svh
// assertion macros for the ring region manager
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/crrm_pkg.sv
// types and constants for the ring region manager
`timescale 1ns / 1ps

package crrm_pkg;

  localparam int FIELD_W    = 13;
  localparam int ACTION_W   = 3;
  localparam int STATUS_W   = 2;
  localparam int TOTAL_W    = 32;
  localparam int BUF_SIZE_DEF = 4096;

  typedef enum logic [ACTION_W-1:0] {
    ACT_RESERVE = 3'd0,
    ACT_COMMIT  = 3'd1,
    ACT_READ    = 3'd2,
    ACT_PEEK    = 3'd3,
    ACT_RELEASE = 3'd4,
    ACT_BACKOFF = 3'd5,
    ACT_REINIT  = 3'd6
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_ROOM   = 2'd1,
    ST_SATURATED = 2'd2
  } status_t;

  typedef struct packed {
    action_t              action;
    logic [FIELD_W-1:0]   length;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [FIELD_W-1:0]   region_offset;
    logic [FIELD_W-1:0]   region_length;
    logic [FIELD_W-1:0]   used_bytes;
  } rsp_t;

endpackage

FILE: design/crrm_ifs.sv
// request and result channel interfaces
`timescale 1ns / 1ps

interface crrm_in_if;
  logic                              valid;
  logic                              ready;
  logic [crrm_pkg::ACTION_W-1:0]     action;
  logic [crrm_pkg::FIELD_W-1:0]      length;

  modport source (output valid, action, length, input ready);
  modport sink   (input valid, action, length, output ready);
endinterface

interface crrm_out_if;
  logic                              valid;
  logic                              ready;
  logic [crrm_pkg::STATUS_W-1:0]     status;
  logic [crrm_pkg::FIELD_W-1:0]      region_offset;
  logic [crrm_pkg::FIELD_W-1:0]      region_length;
  logic [crrm_pkg::FIELD_W-1:0]      used_bytes;

  modport source (output valid, status, region_offset, region_length, used_bytes,
                  input ready);
  modport sink   (input valid, status, region_offset, region_length, used_bytes,
                  output ready);
endinterface

FILE: design/contiguous_ring_region_manager_top.sv
// top level of the contiguous ring region manager
//
// usage
//   in_chan  : request channel (valid/ready), carries action and length
//   out_chan : result channel (valid/ready), carries status, region offset,
//              region length and used byte count, one result per request
//   each request is first captured in an input register; from there it is
//   evaluated against the offset registers, which it updates, while the
//   result register is loaded
// throughput: one request per cycle while out_ready is high; the offset
//   and count updates are a few adds and compares, done in the same cycle
//   that loads the result register
// stall: while the result register is held the input register keeps its
//   request, or, if it is empty, can still accept one further request;
//   in_ready falls only when both registers are full and out_ready is low
// reset: rst_n low at a clock edge empties both registers, sets the write
//   and read offsets, used count and running total to zero and the wrap
//   mark to the buffer size minus one; a reinitialise request does the same
//   to the offset state
`timescale 1ns / 1ps
`include "assert_macros.svh"

module contiguous_ring_region_manager_top #(
  parameter int BUF_SIZE = crrm_pkg::BUF_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  crrm_in_if.sink            in_chan,
  crrm_out_if.source         out_chan
);

  localparam int CW = $clog2(BUF_SIZE + 1);

  // request handoff between the stages
  logic            req_valid;
  crrm_pkg::req_t  req;
  logic            slot_free;
  logic            fire;
  crrm_pkg::rsp_t  rsp_nxt;
  crrm_pkg::rsp_t  rsp_q;

  // ring offset state
  logic [CW-1:0]                 wr_off_r, wr_off_nxt;
  logic [CW-1:0]                 rd_off_r, rd_off_nxt;
  logic [CW-1:0]                 wrap_r, wrap_nxt;
  logic [CW-1:0]                 used_r, used_nxt;
  logic [crrm_pkg::TOTAL_W-1:0]  total_r, total_nxt;

  // a request is executed when it sits in the input register and the
  // result register can take its answer
  assign fire = req_valid && slot_free;

  crrm_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_action (in_chan.action),
    .in_length (in_chan.length),
    .take      (fire),
    .req_valid (req_valid),
    .req       (req)
  );

  crrm_engine #(
    .BUF_SIZE (BUF_SIZE)
  ) u_engine (
    .req        (req),
    .wr_off     (wr_off_r),
    .rd_off     (rd_off_r),
    .wrap       (wrap_r),
    .used       (used_r),
    .total      (total_r),
    .wr_off_nxt (wr_off_nxt),
    .rd_off_nxt (rd_off_nxt),
    .wrap_nxt   (wrap_nxt),
    .used_nxt   (used_nxt),
    .total_nxt  (total_nxt),
    .rsp        (rsp_nxt)
  );

  // offset state only moves when a request is executed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_off_r <= '0;
      rd_off_r <= '0;
      wrap_r   <= CW'(BUF_SIZE - 1);
      used_r   <= '0;
      total_r  <= '0;
    end else if (fire) begin
      wr_off_r <= wr_off_nxt;
      rd_off_r <= rd_off_nxt;
      wrap_r   <= wrap_nxt;
      used_r   <= used_nxt;
      total_r  <= total_nxt;
    end
  end

  crrm_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .rsp_i     (rsp_nxt),
    .slot_free (slot_free),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .rsp_o     (rsp_q)
  );

  assign out_chan.status        = rsp_q.status;
  assign out_chan.region_offset = rsp_q.region_offset;
  assign out_chan.region_length = rsp_q.region_length;
  assign out_chan.used_bytes    = rsp_q.used_bytes;

  // used count never passes the buffer size
  `ASSERT_CLK(a_used_bound, used_r <= CW'(BUF_SIZE), "used count beyond buffer size")

  // write offset and wrap mark stay inside the ring
  `ASSERT_CLK(a_offs_bound, (wr_off_r <= CW'(BUF_SIZE)) && (wrap_r <= CW'(BUF_SIZE)), "offset beyond ring")

  // an executed request always produces a result next cycle
  `ASSERT_CLK(a_fire_result, fire |=> out_chan.valid, "executed request left no result")

  // back-pressure only when both stages are occupied and the sink stalls
  `ASSERT_CLK(a_ready_cause, !in_chan.ready |-> (req_valid && out_chan.valid && !out_chan.ready), "input stalled without cause")

endmodule

FILE: design/crrm_in_reg.sv
// input request register
`timescale 1ns / 1ps

module crrm_in_reg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [crrm_pkg::ACTION_W-1:0]       in_action,
  input  logic [crrm_pkg::FIELD_W-1:0]        in_length,
  input  logic                                take,
  output logic                                req_valid,
  output crrm_pkg::req_t                      req
);

  logic            valid_r;
  crrm_pkg::req_t  req_r;

  // free when empty or being drained this cycle
  assign in_ready  = !valid_r || take;
  assign req_valid = valid_r;
  assign req       = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r.action <= crrm_pkg::action_t'(in_action);
      req_r.length <= in_length;
    end
  end

endmodule

FILE: design/crrm_engine.sv
// next-state and result logic for one request
`timescale 1ns / 1ps

module crrm_engine #(
  parameter int BUF_SIZE = crrm_pkg::BUF_SIZE_DEF,
  localparam int CW = $clog2(BUF_SIZE + 1),
  localparam int AW = ((CW > crrm_pkg::FIELD_W) ? CW : crrm_pkg::FIELD_W) + 1
) (
  input  crrm_pkg::req_t                    req,
  input  logic [CW-1:0]                     wr_off,
  input  logic [CW-1:0]                     rd_off,
  input  logic [CW-1:0]                     wrap,
  input  logic [CW-1:0]                     used,
  input  logic [crrm_pkg::TOTAL_W-1:0]      total,
  output logic [CW-1:0]                     wr_off_nxt,
  output logic [CW-1:0]                     rd_off_nxt,
  output logic [CW-1:0]                     wrap_nxt,
  output logic [CW-1:0]                     used_nxt,
  output logic [crrm_pkg::TOTAL_W-1:0]      total_nxt,
  output crrm_pkg::rsp_t                    rsp
);

  localparam logic [AW-1:0] BUF_A = AW'(BUF_SIZE);
  localparam logic [AW-1:0] END_A = AW'(BUF_SIZE - 1);
  localparam logic [CW-1:0] END_C = CW'(BUF_SIZE - 1);

  logic [AW-1:0] len_a, wr_a, used_a, rd_eff_a, wrap_eff_a;
  logic [AW-1:0] used_plus, wr_plus, want_a, room_a, grant_a;
  logic [CW-1:0] rd_eff, wrap_eff;

  assign len_a     = AW'(req.length);
  assign wr_a      = AW'(wr_off);
  assign used_a    = AW'(used);
  assign used_plus = used_a + len_a;
  assign wr_plus   = wr_a + len_a;

  // read side snaps back to the start once it reaches the wrap mark
  assign rd_eff     = (wrap == rd_off) ? '0 : rd_off;
  assign wrap_eff   = (wrap == rd_off) ? END_C : wrap;
  assign rd_eff_a   = AW'(rd_eff);
  assign wrap_eff_a = AW'(wrap_eff);
  assign want_a     = (used_a > len_a) ? len_a : used_a;
  assign room_a     = (wrap_eff_a > rd_eff_a) ? (wrap_eff_a - rd_eff_a) : '0;
  assign grant_a    = (want_a > room_a) ? room_a : want_a;

  always_comb begin
    wr_off_nxt        = wr_off;
    rd_off_nxt        = rd_off;
    wrap_nxt          = wrap;
    used_nxt          = used;
    total_nxt         = total;
    rsp.status        = crrm_pkg::ST_OK;
    rsp.region_offset = '0;
    rsp.region_length = '0;
    case (req.action)
      crrm_pkg::ACT_RESERVE: begin
        if (used_plus > BUF_A) begin
          rsp.status = crrm_pkg::ST_NO_ROOM;
        end else if (wr_plus <= END_A) begin
          rsp.region_offset = crrm_pkg::FIELD_W'(wr_off);
          rsp.region_length = req.length;
          wr_off_nxt        = CW'(wr_plus);
        end else begin
          // does not fit before the end mark: wrap to the start
          wrap_nxt          = wr_off;
          wr_off_nxt        = CW'(len_a);
          rsp.region_length = req.length;
        end
      end
      crrm_pkg::ACT_COMMIT: begin
        if (used_plus > BUF_A) begin
          used_nxt   = CW'(BUF_SIZE);
          rsp.status = crrm_pkg::ST_SATURATED;
        end else begin
          used_nxt = CW'(used_plus);
        end
        total_nxt = total + crrm_pkg::TOTAL_W'(req.length);
      end
      crrm_pkg::ACT_READ, crrm_pkg::ACT_PEEK: begin
        rd_off_nxt = rd_eff;
        wrap_nxt   = wrap_eff;
        if (used != '0) begin
          rsp.region_offset = crrm_pkg::FIELD_W'(rd_eff);
          rsp.region_length = crrm_pkg::FIELD_W'(grant_a);
          if (req.action == crrm_pkg::ACT_READ) begin
            rd_off_nxt = CW'(rd_eff_a + grant_a);
          end
        end
      end
      crrm_pkg::ACT_RELEASE: begin
        if (len_a > used_a) begin
          used_nxt   = '0;
          rsp.status = crrm_pkg::ST_SATURATED;
        end else begin
          used_nxt = CW'(used_a - len_a);
        end
      end
      crrm_pkg::ACT_BACKOFF: begin
        used_nxt   = (len_a > used_a) ? '0 : CW'(used_a - len_a);
        wr_off_nxt = (len_a > wr_a) ? '0 : CW'(wr_a - len_a);
        if ((len_a > used_a) || (len_a > wr_a)) begin
          rsp.status = crrm_pkg::ST_SATURATED;
        end
      end
      crrm_pkg::ACT_REINIT: begin
        wr_off_nxt = '0;
        rd_off_nxt = '0;
        wrap_nxt   = END_C;
        used_nxt   = '0;
        total_nxt  = '0;
      end
      default: begin
      end
    endcase
    rsp.used_bytes = crrm_pkg::FIELD_W'(used_nxt);
  end

endmodule

FILE: design/crrm_out_reg.sv
// result register
`timescale 1ns / 1ps

module crrm_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  crrm_pkg::rsp_t      rsp_i,
  output logic                slot_free,
  output logic                out_valid,
  input  logic                out_ready,
  output crrm_pkg::rsp_t      rsp_o
);

  logic            valid_r;
  crrm_pkg::rsp_t  rsp_r;

  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign rsp_o     = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (slot_free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_r <= rsp_i;
    end
  end

endmodule
